// ===== rtl/htlp_pkg.sv =====
// shared types and constants for the linear-probing hash table
package htlp_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int HASH_W   = 32;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = 10;
  localparam int MODE_W   = 2;
  localparam int LIMIT_W  = 11;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(768);
  localparam logic [LIMIT_W-1:0] COUNT_MAX   = {LIMIT_W{1'b1}};
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    SLOT_EMPTY  = 2'd0,
    SLOT_FILLED = 2'd1,
    SLOT_TOMB   = 2'd2
  } slot_state_t;

  typedef enum logic [MODE_W-1:0] {
    OP_GET = 2'd0,
    OP_SET = 2'd1,
    OP_DEL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_LOOKUP,
    SQ_EVAL
  } seq_state_t;

  typedef struct packed {
    slot_state_t       st;
    logic [HASH_W-1:0] key;
    logic [VAL_W-1:0]  val;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_entry_t      wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

endpackage

// ===== rtl/htlp_ram.sv =====
// generic single-write, single-read ram with registered read data
module htlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/htlp_seq.sv =====
// probe sequencer: clearing sweep, slot-by-slot probe with one shared compare, result
module htlp_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [htlp_pkg::MODE_W-1:0]      mode,
  input  logic [htlp_pkg::HASH_W-1:0]      key_hash,
  input  logic [htlp_pkg::VAL_W-1:0]       value,
  input  logic [htlp_pkg::LIMIT_W-1:0]     load_limit,
  output logic                             busy,
  output logic                             done,
  output htlp_pkg::result_t                result,
  output htlp_pkg::ram_req_t               ram_req,
  input  htlp_pkg::slot_entry_t            ram_rdata
);
  import htlp_pkg::*;

  seq_state_t          state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [IDX_W-1:0]    start_idx, start_idx_next;
  logic [IDX_W-1:0]    n, n_next;
  logic [IDX_W-1:0]    free_idx, free_idx_next;
  logic                has_free, has_free_next;
  logic [MODE_W-1:0]   op, op_next;
  logic [HASH_W-1:0]   h, h_next;
  logic [VAL_W-1:0]    v, v_next;
  logic [LIMIT_W-1:0]  insert_count, insert_count_next;
  logic                done_next;
  result_t             result_next;

  logic                is_empty, is_hit, is_last, free_now;
  logic [IDX_W-1:0]    fs_now, miss_slot, idx_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SQ_CLEAR;
      idx          <= '0;
      insert_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      insert_count <= insert_count_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    start_idx <= start_idx_next;
    n         <= n_next;
    free_idx  <= free_idx_next;
    has_free  <= has_free_next;
    op        <= op_next;
    h         <= h_next;
    v         <= v_next;
    result    <= result_next;
  end

  // shared compare on the slot just read
  assign is_empty  = (ram_rdata.st == SLOT_EMPTY);
  assign is_hit    = (ram_rdata.st == SLOT_FILLED) && (ram_rdata.key == h);
  assign is_last   = (n == LAST_IDX);
  assign free_now  = has_free || (ram_rdata.st != SLOT_FILLED);
  assign fs_now    = has_free ? free_idx : idx;
  assign miss_slot = is_empty ? idx : start_idx;
  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;

  assign busy = (state != SQ_IDLE);

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    start_idx_next    = start_idx;
    n_next            = n;
    free_idx_next     = free_idx;
    has_free_next     = has_free;
    op_next           = op;
    h_next            = h;
    v_next            = v;
    insert_count_next = insert_count;
    done_next         = 1'b0;
    result_next       = result;
    ram_req.we        = 1'b0;
    ram_req.waddr     = idx;
    ram_req.wdata     = ram_rdata;
    ram_req.raddr     = idx;

    unique case (state)
      SQ_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '0;
        idx_next      = idx_inc;
        if (idx == LAST_IDX) begin
          state_next = SQ_IDLE;
        end
      end

      SQ_IDLE: begin
        if (start) begin
          start_idx_next = key_hash[IDX_W-1:0];
          idx_next       = key_hash[IDX_W-1:0];
          n_next         = '0;
          has_free_next  = 1'b0;
          op_next        = mode;
          h_next         = key_hash;
          v_next         = value;
          if (mode == OP_GET || mode == OP_SET || mode == OP_DEL) begin
            state_next = SQ_LOOKUP;
          end else begin
            // unused mode: nothing touched, answered at once
            done_next               = 1'b1;
            result_next.status      = STAT_MISS;
            result_next.found_value = '0;
            result_next.slot_index  = SLOT_W'(key_hash[IDX_W-1:0]);
          end
        end
      end

      SQ_LOOKUP: begin
        state_next = SQ_EVAL;
      end

      SQ_EVAL: begin
        if (is_hit || is_empty || is_last) begin
          state_next              = SQ_IDLE;
          done_next               = 1'b1;
          result_next.found_value = '0;
          if (op == OP_SET) begin
            if (is_hit) begin
              ram_req.we              = 1'b1;
              ram_req.wdata.val       = v;
              result_next.status      = STAT_OK;
              result_next.slot_index  = SLOT_W'(idx);
            end else if (!free_now) begin
              result_next.status      = STAT_FULL;
              result_next.slot_index  = SLOT_W'(start_idx);
            end else if (insert_count >= load_limit) begin
              result_next.status      = STAT_FULL;
              result_next.slot_index  = SLOT_W'(fs_now);
            end else begin
              ram_req.we              = 1'b1;
              ram_req.waddr           = fs_now;
              ram_req.wdata.st        = SLOT_FILLED;
              ram_req.wdata.key       = h;
              ram_req.wdata.val       = v;
              if (insert_count != COUNT_MAX) begin
                insert_count_next = insert_count + 1'b1;
              end
              result_next.status      = STAT_OK;
              result_next.slot_index  = SLOT_W'(fs_now);
            end
          end else if (is_hit) begin
            result_next.status      = STAT_OK;
            result_next.slot_index  = SLOT_W'(idx);
            if (op == OP_DEL) begin
              ram_req.we       = 1'b1;
              ram_req.wdata.st = SLOT_TOMB;
            end else begin
              result_next.found_value = ram_rdata.val;
            end
          end else begin
            result_next.status      = STAT_MISS;
            result_next.slot_index  = SLOT_W'(miss_slot);
          end
        end else begin
          // first tombstone passed is remembered as the insert point
          if (!has_free && ram_rdata.st != SLOT_FILLED) begin
            has_free_next = 1'b1;
            free_idx_next = idx;
          end
          idx_next   = idx_inc;
          n_next     = n + 1'b1;
          state_next = SQ_LOOKUP;
        end
      end

      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hash_table_linear_probe.sv =====
// top level: load limit register, probe sequencer and slot memory
//
//  channel   signals                          direction  beat when
//  command   start, mode, key_hash, value     in         start & !busy
//  result    done, status, found_value,       out        done (one cycle)
//            slot_index
//  config    cfg_we, cfg_wdata (load_limit)   in         cfg_we
//
// each probed slot takes a read issue step and a compare step on the single slot
// memory read port; an item stays busy while it probes, and its result beat follows
// in the cycle after the last compare, in which a new command can already be taken.
// unused mode 3 answers in the cycle after acceptance without probing.
// after reset a clearing sweep writes every slot empty, one per cycle, and busy
// stays high until it ends; config writes are taken throughout.
// results cannot be stalled: each is shown for exactly one cycle.
module hash_table_linear_probe (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [htlp_pkg::MODE_W-1:0]  mode,
  input  logic [htlp_pkg::HASH_W-1:0]  key_hash,
  input  logic [htlp_pkg::VAL_W-1:0]   value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [htlp_pkg::VAL_W-1:0]   found_value,
  output logic [htlp_pkg::SLOT_W-1:0]  slot_index,
  input  logic                         cfg_we,
  input  logic [htlp_pkg::LIMIT_W-1:0] cfg_wdata
);
  import htlp_pkg::*;

  logic [LIMIT_W-1:0] load_limit;
  result_t            result;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      load_limit <= cfg_wdata;
    end
  end

  htlp_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .key_hash   (key_hash),
    .value      (value),
    .load_limit (load_limit),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .ram_req    (ram_req),
    .ram_rdata  (slot_entry_t'(ram_rdata))
  );

  htlp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign status      = result.status;
  assign found_value = result.found_value;
  assign slot_index  = result.slot_index;

  // an accepted command either starts a probe or is answered at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither probing nor answered");

  // only a successful lookup returns a value
  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (found_value == '0))
    else $error("found_value set on a failed operation");

  // clearing sweep holds the command side off right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy at the start of the clearing sweep");

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the linear-probing hash table: tracker class, drive tasks, top
`timescale 1ns / 1ps

import htlp_pkg::*;

localparam logic [MODE_W-1:0] OP_UNUSED = 2'd3;

class slot_table_tracker;
  slot_state_t        slot_state [CAPACITY];
  logic [HASH_W-1:0]  slot_key   [CAPACITY];
  logic [VAL_W-1:0]   slot_val   [CAPACITY];
  logic [LIMIT_W-1:0] insert_count;
  logic [LIMIT_W-1:0] load_limit;
  result_t            outcomes_due [$];
  int                 errors;

  function new();
    foreach (slot_state[i]) begin
      slot_state[i] = SLOT_EMPTY;
      slot_key[i]   = '0;
      slot_val[i]   = '0;
    end
    insert_count = '0;
    load_limit   = LIMIT_RESET;
    errors       = 0;
  endfunction

  function result_t lookup_outcome(logic [MODE_W-1:0] op, logic [HASH_W-1:0] key,
                                   logic [VAL_W-1:0] val);
    int      start_slot, idx, probed, hit_slot, stop_slot, free_slot, miss_slot;
    bit      searching, hit, has_free, exhausted;
    result_t res;
    start_slot = int'(key % CAPACITY);
    idx        = start_slot;
    stop_slot  = start_slot;
    free_slot  = 0;
    hit_slot   = 0;
    probed     = 0;
    hit        = 1'b0;
    has_free   = 1'b0;
    exhausted  = 1'b0;
    searching  = (op != OP_UNUSED);
    while (searching) begin
      if (slot_state[idx] == SLOT_EMPTY) begin
        if (!has_free) begin
          has_free  = 1'b1;
          free_slot = idx;
        end
        stop_slot = idx;
        searching = 1'b0;
      end else if (slot_state[idx] == SLOT_FILLED && slot_key[idx] == key) begin
        hit       = 1'b1;
        hit_slot  = idx;
        searching = 1'b0;
      end else begin
        // first tombstone passed is where an insert would land
        if (slot_state[idx] == SLOT_TOMB && !has_free) begin
          has_free  = 1'b1;
          free_slot = idx;
        end
        idx = (idx + 1) % CAPACITY;
        probed++;
        if (probed == CAPACITY) begin
          exhausted = 1'b1;
          searching = 1'b0;
        end
      end
    end
    miss_slot       = exhausted ? start_slot : stop_slot;
    res.status      = STAT_MISS;
    res.found_value = '0;
    res.slot_index  = SLOT_W'(start_slot);
    case (op)
      OP_GET: begin
        if (hit) begin
          res.status      = STAT_OK;
          res.found_value = slot_val[hit_slot];
          res.slot_index  = SLOT_W'(hit_slot);
        end else begin
          res.slot_index = SLOT_W'(miss_slot);
        end
      end
      OP_SET: begin
        if (hit) begin
          slot_val[hit_slot] = val;
          res.status         = STAT_OK;
          res.slot_index     = SLOT_W'(hit_slot);
        end else if (!has_free) begin
          res.status = STAT_FULL;
        end else if (insert_count >= load_limit) begin
          res.status     = STAT_FULL;
          res.slot_index = SLOT_W'(free_slot);
        end else begin
          slot_state[free_slot] = SLOT_FILLED;
          slot_key[free_slot]   = key;
          slot_val[free_slot]   = val;
          if (insert_count != COUNT_MAX) insert_count = insert_count + 1'b1;
          res.status     = STAT_OK;
          res.slot_index = SLOT_W'(free_slot);
        end
      end
      OP_DEL: begin
        if (hit) begin
          slot_state[hit_slot] = SLOT_TOMB;
          res.status           = STAT_OK;
          res.slot_index       = SLOT_W'(hit_slot);
        end else begin
          res.slot_index = SLOT_W'(miss_slot);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function void note_command(logic [MODE_W-1:0] op, logic [HASH_W-1:0] key,
                             logic [VAL_W-1:0] val);
    outcomes_due.push_back(lookup_outcome(op, key, val));
  endfunction

  function void check_result(logic [1:0] st, logic [VAL_W-1:0] fv, logic [SLOT_W-1:0] si);
    result_t due;
    if (outcomes_due.size() == 0) begin
      $error("result beat with no command outstanding");
      errors++;
    end else begin
      due = outcomes_due.pop_front();
      if (st !== due.status) begin
        $error("status: expected %0d, got %0d", due.status, st);
        errors++;
      end
      if (fv !== due.found_value) begin
        $error("found_value: expected %h, got %h", due.found_value, fv);
        errors++;
      end
      if (si !== due.slot_index) begin
        $error("slot_index: expected %0d, got %0d", due.slot_index, si);
        errors++;
      end
    end
  endfunction
endclass

module tb;
  localparam int          STALL_LIMIT = 20000;
  localparam int          POOL_SIZE   = 256;
  localparam int          PHASE_ITEMS = 50;
  localparam logic [21:0] FILL_TAG    = 22'h2B5A3C;
  localparam logic [21:0] MISS_TAG    = 22'h1C3D5E;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  mode;
  logic [HASH_W-1:0]  key_hash;
  logic [VAL_W-1:0]   value;
  logic               done;
  logic [1:0]         status;
  logic [VAL_W-1:0]   found_value;
  logic [SLOT_W-1:0]  slot_index;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  int                 stall_cycles = 0;
  slot_table_tracker  table_model;
  logic [HASH_W-1:0]  key_pool [POOL_SIZE];
  int                 phase_idle [4] = '{0, 64, 0, 32};

  hash_table_linear_probe u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .key_hash    (key_hash),
    .value       (value),
    .done        (done),
    .status      (status),
    .found_value (found_value),
    .slot_index  (slot_index),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done !== 1'b0) table_model.check_result(status, found_value, slot_index);
  end

  always @(posedge clk) begin
    if (done === 1'b1 || (start === 1'b1 && busy === 1'b0)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // start stays high on return so back-to-back beats need no extra step
  task automatic drive_command(input logic [MODE_W-1:0] op, input logic [HASH_W-1:0] key,
                               input logic [VAL_W-1:0] val);
    start    <= 1'b1;
    mode     <= op;
    key_hash <= key;
    value    <= val;
    do @(posedge clk); while (busy !== 1'b0);
    table_model.note_command(op, key, val);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (table_model.outcomes_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_load_limit(input logic [LIMIT_W-1:0] limit);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_model.load_limit = limit;
  endtask

  initial begin : stimulus
    int                 gap, pick;
    logic [HASH_W-1:0]  k;
    logic [MODE_W-1:0]  op;
    logic [VAL_W-1:0]   v;
    logic [LIMIT_W-1:0] limit;
    int                 tomb_slots [$];
    int                 empty_slots [$];
    table_model = new();
    rst       <= 1'b1;
    start     <= 1'b0;
    mode      <= OP_GET;
    key_hash  <= '0;
    value     <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    // a quarter of the keys crowd around the wrap point to build long chains
    for (int i = 0; i < POOL_SIZE; i++) begin
      do begin
        key_pool[i] = $urandom();
        if (i % 4 == 0) key_pool[i][IDX_W-1:0] = IDX_W'(CAPACITY - 8 + $urandom_range(15));
      end while (key_pool[i][HASH_W-1:IDX_W] == FILL_TAG ||
                 key_pool[i][HASH_W-1:IDX_W] == MISS_TAG);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // refusals with a zero limit, written while the clearing sweep runs; the commands wait for its end
    set_load_limit('0);
    drive_command(OP_SET, 32'h0000_0005, 32'hFFFF_FFFF);
    drive_command(OP_GET, 32'h0000_0005, 32'h0);
    drive_command(OP_DEL, 32'h0000_0005, 32'h0);
    drive_command(OP_UNUSED, 32'hFFFF_FFFF, 32'h0);

    set_load_limit(LIMIT_W'(CAPACITY));
    drive_command(OP_SET, 32'h0000_0000, 32'h0000_0000);
    drive_command(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drive_command(OP_SET, 32'h0000_0400, 32'hA5A5_A5A5);
    drive_command(OP_SET, 32'hFFFF_FC00, 32'h1234_5678);
    drive_command(OP_GET, 32'h0000_0400, 32'h0);
    drive_command(OP_SET, 32'h0000_0400, 32'h5A5A_5A5A);
    drive_command(OP_GET, 32'h0000_0400, 32'h0);
    drive_command(OP_DEL, 32'h0000_0400, 32'h0);
    drive_command(OP_GET, 32'hFFFF_FC00, 32'h0);
    drive_command(OP_GET, 32'h0000_0400, 32'h0);
    drive_command(OP_SET, 32'h0000_0800, 32'h0F0F_0F0F);
    // probe from the last slot wraps round to the front
    drive_command(OP_SET, 32'h0000_07FF, 32'h8765_4321);
    drive_command(OP_GET, 32'h0000_07FF, 32'h0);
    drive_command(OP_DEL, 32'hFFFF_FFFF, 32'h0);
    drive_command(OP_GET, 32'h0000_07FF, 32'h0);
    drive_command(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
    drive_command(OP_DEL, 32'h0000_0400, 32'h0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       limit = COUNT_MAX;
        1:       limit = LIMIT_W'(CAPACITY);
        2:       limit = table_model.insert_count + LIMIT_W'(12);
        default: limit = COUNT_MAX;
      endcase
      set_load_limit(limit);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(59) == 0) wait_drained();
        gap = 0;
        while ($urandom_range(99) < phase_idle[p]) gap++;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pick = $urandom_range(99);
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
        else k = $urandom();
        v = $urandom();
        case ($urandom_range(15))
          0:       v = '0;
          1:       v = '1;
          default: ;
        endcase
        if (pick < 38) op = OP_GET;
        else if (pick < 75) op = OP_SET;
        else if (pick < 97) op = OP_DEL;
        else op = OP_UNUSED;
        drive_command(op, k, v);
      end
    end

    // fill every tombstone and empty slot so the table is completely full
    set_load_limit(COUNT_MAX);
    foreach (table_model.slot_state[i]) begin
      if (table_model.slot_state[i] == SLOT_TOMB) tomb_slots.push_back(i);
      else if (table_model.slot_state[i] == SLOT_EMPTY) empty_slots.push_back(i);
    end
    foreach (tomb_slots[j]) drive_command(OP_SET, {FILL_TAG, IDX_W'(tomb_slots[j])}, $urandom());
    foreach (empty_slots[j])
      drive_command(OP_SET, {FILL_TAG, IDX_W'(empty_slots[j])}, $urandom());

    // full table: misses run every slot, a new key finds nowhere to go
    drive_command(OP_GET, {MISS_TAG, IDX_W'(0)}, $urandom());
    drive_command(OP_DEL, {MISS_TAG, LAST_IDX}, $urandom());
    drive_command(OP_SET, {MISS_TAG, IDX_W'(77)}, $urandom());
    drive_command(OP_SET, {FILL_TAG, IDX_W'(5)}, 32'hFFFF_FFFF);
    drive_command(OP_GET, {FILL_TAG, IDX_W'(5)}, 32'h0);
    drive_command(OP_DEL, {FILL_TAG, IDX_W'(9)}, 32'h0);
    drive_command(OP_SET, {MISS_TAG, IDX_W'(4)}, $urandom());
    drive_command(OP_GET, {MISS_TAG, IDX_W'(4)}, 32'h0);
    drive_command(OP_DEL, {FILL_TAG, IDX_W'(12)}, 32'h0);
    drive_command(OP_DEL, key_pool[1], 32'h0);
    set_load_limit(table_model.insert_count);
    drive_command(OP_SET, {MISS_TAG, IDX_W'(300)}, $urandom());

    wait_drained();
    repeat (8) @(posedge clk);
    if (table_model.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
